// File: rtl/lda_pkg.sv
`timescale 1ns / 1ps

package lda_pkg;

    localparam int LINE_BITS_DEF = 32;

    localparam logic [1:0] CMD_SCRIPT_BYTE = 2'd0;
    localparam logic [1:0] CMD_ORIG_BYTE   = 2'd1;
    localparam logic [1:0] CMD_SCRIPT_END  = 2'd2;
    localparam logic [1:0] CMD_ORIG_END    = 2'd3;

    localparam logic [7:0] CHAR_APPEND  = 8'h61;
    localparam logic [7:0] CHAR_DELETE  = 8'h64;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic       error_flag;
        logic       finished;
        logic       want_source;
        logic [7:0] out_byte;
        logic       emit;
    } t_result;

endpackage

// File: rtl/line_diff_script_applier.sv
`timescale 1ns / 1ps

// Channel  Direction  Word                     tdata fields (low up)                 tuser
// s_axis   in         script or original byte  data_byte[7:0]                        command[1:0]
// m_axis   out        one status per word      out_byte, want_source, finished, err  emit
//
// Every accepted word yields exactly one output word via the input and core registers.
// Throughput is one word per cycle while the output is not stalled; the state update is a single registered step.
// Reset is synchronous and active low and returns the block to waiting for a command.
// A stalled output holds its word and the input side stops after one buffered word.

module line_diff_script_applier #(
    parameter int LINE_BITS = lda_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte[7:0]
    input  logic [1:0]  i_s_axis_tuser,   // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // out_byte[7:0], want_source[8], finished[9],
                                          // error_flag[10], zero[15:11]
    output logic [0:0]  o_m_axis_tuser    // emit[0]
);
    import lda_pkg::*;

    t_in_word in_word;
    t_in_word stage_word;
    t_result  result;
    logic     stage_valid;
    logic     core_ready;

    assign in_word.cmd       = i_s_axis_tuser;
    assign in_word.data_byte = i_s_axis_tdata;

    lda_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (in_word),
        .o_valid (stage_valid),
        .i_ready (core_ready),
        .o_word  (stage_word)
    );

    lda_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (core_ready),
        .i_word   (stage_word),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {5'b00000, result.error_flag, result.finished,
                             result.want_source, result.out_byte};
    assign o_m_axis_tuser = result.emit;

endmodule

// File: rtl/lda_in_stage.sv
`timescale 1ns / 1ps

module lda_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lda_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output lda_pkg::t_in_word o_word
);
    import lda_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// File: rtl/lda_core.sv
`timescale 1ns / 1ps

module lda_core #(
    parameter int LINE_BITS = lda_pkg::LINE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lda_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output lda_pkg::t_result  o_result
);
    import lda_pkg::*;

    localparam int AW = LINE_BITS + 4;

    typedef enum logic [7:0] {
        PH_LETTER = 8'b0000_0001,
        PH_LINE   = 8'b0000_0010,
        PH_COUNT  = 8'b0000_0100,
        PH_COPY   = 8'b0000_1000,
        PH_SKIP   = 8'b0001_0000,
        PH_APPEND = 8'b0010_0000,
        PH_TAIL   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    t_phase               r_phase, n_phase;
    logic                 r_app, n_app;
    logic [LINE_BITS-1:0] r_cur, n_cur;
    logic [LINE_BITS-1:0] r_tgt, n_tgt;
    logic [LINE_BITS-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic                 r_fail, n_fail;
    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 advance;
    logic                 from_orig;
    logic                 is_end;
    logic                 is_digit;
    logic                 wants_orig;
    logic [3:0]           digit;
    logic [AW-1:0]        acc_tgt;
    logic [AW-1:0]        acc_cnt;
    logic [LINE_BITS-1:0] cur_bumped;
    logic                 more;

    function automatic logic [AW-1:0] mul10_add(input logic [LINE_BITS-1:0] v,
                                                input logic [3:0] d);
        logic [AW-1:0] w;
        w = {4'b0000, v};
        return (w << 3) + (w << 1) + {{(AW-4){1'b0}}, d};
    endfunction

    function automatic logic phase_wants_orig(input t_phase p);
        return (p == PH_COPY) || (p == PH_SKIP) || (p == PH_TAIL);
    endfunction

    assign advance    = i_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_out_valid || i_ready;
    assign from_orig  = (i_word.cmd == CMD_ORIG_BYTE) || (i_word.cmd == CMD_ORIG_END);
    assign is_end     = (i_word.cmd == CMD_SCRIPT_END) || (i_word.cmd == CMD_ORIG_END);
    assign is_digit   = (i_word.data_byte >= CHAR_ZERO) && (i_word.data_byte <= CHAR_NINE);
    assign digit      = 4'(i_word.data_byte - CHAR_ZERO);
    assign wants_orig = phase_wants_orig(r_phase);
    assign acc_tgt    = mul10_add(r_tgt, digit);
    assign acc_cnt    = mul10_add(r_cnt, digit);
    assign cur_bumped = (r_cur == {LINE_BITS{1'b1}}) ? r_cur : r_cur + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_app   = r_app;
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_cnt   = r_cnt;
        n_done  = r_done;
        n_fail  = r_fail;
        n_out   = '0;
        more    = 1'b0;

        if ((r_phase != PH_DONE) && (from_orig == wants_orig)) begin
            unique case (r_phase)
                PH_LETTER: begin
                    if (is_end) begin
                        n_phase = PH_TAIL;
                    end else if ((i_word.data_byte == CHAR_APPEND) ||
                                 (i_word.data_byte == CHAR_DELETE)) begin
                        n_app   = (i_word.data_byte == CHAR_APPEND);
                        n_tgt   = '0;
                        n_phase = PH_LINE;
                    end else begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end
                end
                PH_LINE: begin
                    if (!is_end && is_digit && (acc_tgt[AW-1:LINE_BITS] == 4'd0)) begin
                        n_tgt = acc_tgt[LINE_BITS-1:0];
                    end else if (!is_end && (i_word.data_byte == CHAR_SPACE)) begin
                        n_cnt   = '0;
                        n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (!is_end && is_digit && (acc_cnt[AW-1:LINE_BITS] == 4'd0)) begin
                        n_cnt = acc_cnt[LINE_BITS-1:0];
                    end else if (!is_end && (i_word.data_byte == CHAR_NEWLINE)) begin
                        n_phase = PH_COPY;
                    end else begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end
                end
                PH_COPY: begin
                    if (is_end) begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end else begin
                        n_out.emit     = 1'b1;
                        n_out.out_byte = i_word.data_byte;
                        if (i_word.data_byte == CHAR_NEWLINE) begin
                            n_cur = cur_bumped;
                        end
                    end
                end
                PH_SKIP: begin
                    if (is_end) begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end else if (i_word.data_byte == CHAR_NEWLINE) begin
                        n_cnt = r_cnt - 1'b1;
                        n_cur = cur_bumped;
                    end
                end
                PH_APPEND: begin
                    if (is_end) begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b1;
                    end else begin
                        n_out.emit     = 1'b1;
                        n_out.out_byte = i_word.data_byte;
                        if (i_word.data_byte == CHAR_NEWLINE) begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                end
                PH_TAIL: begin
                    if (is_end) begin
                        n_phase = PH_DONE;
                        n_fail  = 1'b0;
                    end else begin
                        n_out.emit     = 1'b1;
                        n_out.out_byte = i_word.data_byte;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                    n_fail  = 1'b1;
                end
            endcase

            if (n_phase == PH_DONE) begin
                n_done = 1'b1;
            end

            // Leave the copy, skip and append phases at once when nothing is left to do.
            if (n_phase == PH_COPY) begin
                more = n_app ? (n_cur <= n_tgt) : (n_cur < n_tgt);
                if (!more) begin
                    n_phase = n_app ? PH_APPEND : PH_SKIP;
                end
            end
            if (((n_phase == PH_SKIP) || (n_phase == PH_APPEND)) && (n_cnt == '0)) begin
                n_phase = PH_LETTER;
            end
        end

        n_out.want_source = (n_phase != PH_DONE) && phase_wants_orig(n_phase);
        n_out.finished    = n_done;
        n_out.error_flag  = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LETTER;
            r_app       <= 1'b0;
            r_cur       <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            r_tgt       <= '0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_app       <= n_app;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_cnt       <= n_cnt;
            r_done      <= n_done;
            r_fail      <= n_fail;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished state was left");

    a_fail_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail |-> r_done)
        else $error("error flag set while still processing");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == PH_DONE))
        else $error("finished flag and phase disagree");

    a_finished_no_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |-> (!r_out.want_source && !r_out.emit))
        else $error("finished result still requests input or emits a byte");

endmodule
